// File: hdl/mrfr_pkg.sv
// Shared types, codes and constants of the Modbus RTU frame receiver.
package mrfr_pkg;

  // Default frame buffer size in bytes
  localparam int FRAME_BYTES_DEF = 256;

  // Fixed field widths of the channels
  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 9;
  localparam int TIME_W   = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // Silence counter ceiling
  localparam logic [TIME_W-1:0] SILENCE_MAX = '1;

  // Action codes of the input channel
  typedef enum logic [ACTION_W-1:0] {
    ACT_BYTE     = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_READ     = 3'd2,
    ACT_FLUSH    = 3'd3,
    ACT_TX_BEGIN = 3'd4
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_LIMIT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT = 4'd3;

  // Configuration register set
  typedef struct packed {
    logic [TIME_W-1:0] gap_limit_us;
    logic [TIME_W-1:0] end_limit_us;
    logic [LEN_W-1:0]  frame_capacity;
    logic [LEN_W-1:0]  read_limit;
  } cfg_t;

  // Status of one result, everything but the delivered byte
  typedef struct packed {
    logic             receiving;
    logic [LEN_W-1:0] bytes_pending;
    logic             frame_waiting;
    logic [LEN_W-1:0] frame_length;
    logic             data_valid;
    logic             data_last;
  } status_t;

endpackage

// File: hdl/mrfr_ifs.sv
// Channel interfaces: action input, result output and configuration write.
interface mrfr_in_if import mrfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface mrfr_out_if import mrfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              receiving;
  logic [LEN_W-1:0]  bytes_pending;
  logic              frame_waiting;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic              data_last;
  modport source (output valid, receiving, bytes_pending, frame_waiting, frame_length,
                  data_byte, data_valid, data_last, input ready);
  modport sink (input valid, receiving, bytes_pending, frame_waiting, frame_length,
                data_byte, data_valid, data_last, output ready);
endinterface

interface mrfr_cfg_if import mrfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/mrfr_cfg_regs.sv
// Configuration register file of the frame receiver.
module mrfr_cfg_regs import mrfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mrfr_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t regs;

  assign cfg_ch.ready = 1'b1;
  assign cfg       = regs;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gap_limit_us   <= TIME_W'(750);
      regs.end_limit_us   <= TIME_W'(1750);
      regs.frame_capacity <= LEN_W'(256);
      regs.read_limit     <= LEN_W'(256);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GAP_LIMIT:  regs.gap_limit_us   <= cfg_ch.data;
        REG_END_LIMIT:  regs.end_limit_us   <= cfg_ch.data;
        REG_FRAME_CAP:  regs.frame_capacity <= cfg_ch.data[LEN_W-1:0];
        REG_READ_LIMIT: regs.read_limit     <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/mrfr_frame_ram.sv
// Ping-pong frame RAM: two banks of frame bytes, one write and one read port.
module mrfr_frame_ram import mrfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int RAW = $clog2(FRAME_BYTES) + 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [RAW-1:0]    wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [RAW-1:0]    rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  // Each bank spans the full address range below the bank bit
  logic [BYTE_W-1:0] mem [2**RAW];

  // Store an assembled byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Fetch a delivered byte; hold the data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/mrfr_frame_ctrl.sv
// Frame control: silence timing, assembly and delivery bookkeeping, RAM requests.
module mrfr_frame_ctrl import mrfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int AW  = $clog2(FRAME_BYTES),
  localparam int RAW = AW + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [ACTION_W-1:0] action,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output logic              wr_en,
  output logic [RAW-1:0]    wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              rd_en,
  output logic [RAW-1:0]    rd_addr,
  output status_t           status
);

  localparam int CW = ($clog2(FRAME_BYTES + 1) > LEN_W) ? $clog2(FRAME_BYTES + 1) : LEN_W;
  localparam logic [CW-1:0] FB = CW'(FRAME_BYTES);

  logic              assembling, assembling_next;
  logic [CW-1:0]     count, count_next;
  logic              armed, armed_next;
  logic [TIME_W-1:0] silence, silence_next;
  logic              pending, pending_next;
  logic [CW-1:0]     dlen, dlen_next;
  logic [CW-1:0]     rpos, rpos_next;
  logic              bank, bank_next;

  logic [CW-1:0]     cap_ext, ucap, rl_ext, lim, rpos_inc;
  logic [TIME_W-1:0] silence_inc;
  logic              data_valid, data_last;

  // Clamp the capacity to one..FRAME_BYTES
  always_comb begin
    cap_ext = CW'(cfg.frame_capacity);
    if (cap_ext == '0) begin
      ucap = CW'(1);
    end else if (cap_ext > FB) begin
      ucap = FB;
    end else begin
      ucap = cap_ext;
    end
    rl_ext      = CW'(cfg.read_limit);
    lim         = (dlen < rl_ext) ? dlen : rl_ext;
    rpos_inc    = rpos + CW'(1);
    silence_inc = (silence < SILENCE_MAX) ? silence + TIME_W'(1) : silence;
  end

  // Next state and RAM requests for the accepted action
  always_comb begin
    assembling_next = assembling;
    count_next      = count;
    armed_next      = armed;
    silence_next    = silence;
    pending_next    = pending;
    dlen_next       = dlen;
    rpos_next       = rpos;
    bank_next       = bank;
    wr_en           = 1'b0;
    wr_addr         = {bank, AW'(0)};
    wr_data         = rx_byte;
    rd_en           = 1'b0;
    rd_addr         = {~bank, rpos[AW-1:0]};
    data_valid      = 1'b0;
    data_last       = 1'b0;
    if (fire) begin
      case (action_t'(action))
        ACT_BYTE: begin
          if (!assembling || silence > cfg.gap_limit_us) begin
            if (assembling && pending) begin
              // gap with a frame still waiting: stop assembly, lose the byte
              assembling_next = 1'b0;
              count_next      = '0;
              armed_next      = 1'b0;
            end else if (!pending || assembling) begin
              // open a new frame with this byte
              wr_en           = 1'b1;
              count_next      = CW'(1);
              assembling_next = 1'b1;
              silence_next    = '0;
              armed_next      = 1'b1;
            end
          end else begin
            if (count < ucap) begin
              wr_en      = 1'b1;
              wr_addr    = {bank, count[AW-1:0]};
              count_next = count + CW'(1);
            end
            silence_next = '0;
            armed_next   = 1'b1;
          end
        end
        ACT_TICK: begin
          silence_next = silence_inc;
          if (armed && assembling && silence_inc >= cfg.end_limit_us) begin
            assembling_next = 1'b0;
            count_next      = '0;
            armed_next      = 1'b0;
            if (count != '0 && !pending) begin
              // hand the frame over by swapping banks
              dlen_next    = (count > ucap) ? ucap : count;
              pending_next = 1'b1;
              rpos_next    = '0;
              bank_next    = ~bank;
            end
          end
        end
        ACT_READ: begin
          if (rl_ext != '0 && pending && dlen != '0 && rpos < dlen) begin
            rd_en      = 1'b1;
            data_valid = 1'b1;
            rpos_next  = rpos_inc;
            if (rpos_inc >= lim) begin
              data_last    = 1'b1;
              pending_next = 1'b0;
              dlen_next    = '0;
              rpos_next    = '0;
            end
          end
        end
        ACT_FLUSH, ACT_TX_BEGIN: begin
          assembling_next = 1'b0;
          count_next      = '0;
          armed_next      = 1'b0;
          pending_next    = 1'b0;
          dlen_next       = '0;
          rpos_next       = '0;
        end
        default: ;
      endcase
    end
    status.receiving     = assembling_next;
    status.bytes_pending = assembling_next ? count_next[LEN_W-1:0] : '0;
    status.frame_waiting = pending_next;
    status.frame_length  = dlen_next[LEN_W-1:0];
    status.data_valid    = data_valid;
    status.data_last     = data_last;
  end

  // Hold the bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      assembling <= 1'b0;
      count      <= '0;
      armed      <= 1'b0;
      silence    <= '0;
      pending    <= 1'b0;
      dlen       <= '0;
      rpos       <= '0;
      bank       <= 1'b0;
    end else begin
      assembling <= assembling_next;
      count      <= count_next;
      armed      <= armed_next;
      silence    <= silence_next;
      pending    <= pending_next;
      dlen       <= dlen_next;
      rpos       <= rpos_next;
      bank       <= bank_next;
    end
  end

endmodule

// File: hdl/mrfr_out_stage.sv
// Result stage: holds the status in a register while the RAM data arrives, then holds the result for the sink.
module mrfr_out_stage import mrfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  status_t           status,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              s0_ready,
  mrfr_out_if.source        out_ch
);

  logic              s1_valid;
  status_t           s1_status;
  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_byte;
  logic              s1_move;

  assign s1_move  = s1_valid && (!out_valid || out_ch.ready);
  assign s0_ready = !s1_valid || s1_move;

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture status, then merge in the RAM byte
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_status <= status;
    end
    if (s1_move) begin
      out_status <= s1_status;
      out_byte   <= s1_status.data_valid ? rd_data : '0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.receiving     = out_status.receiving;
  assign out_ch.bytes_pending = out_status.bytes_pending;
  assign out_ch.frame_waiting = out_status.frame_waiting;
  assign out_ch.frame_length  = out_status.frame_length;
  assign out_ch.data_byte     = out_byte;
  assign out_ch.data_valid    = out_status.data_valid;
  assign out_ch.data_last     = out_status.data_last;

endmodule

// File: hdl/modbus_rtu_frame_receiver.sv
// Modbus RTU frame receiver: delimits frames by line silence and delivers them bytewise.
// One action (byte, microsecond tick, read, flush, transmit begin) is accepted every clock
// while the result channel keeps up, and yields exactly one result: it waits in a status
// register for the registered read of the frame RAM, then in the output register; the rate
// of one action per clock is set by the RAM's single write and single read port. The RAM
// holds two banks of FRAME_BYTES bytes: one assembles while the other delivers, and a
// completed frame is handed over by swapping banks, so no copy and no clearing pass is
// needed after reset. Configuration writes are taken at any time and apply to the next action.
module modbus_rtu_frame_receiver import mrfr_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mrfr_in_if.sink     in_ch,
  mrfr_out_if.source  out_ch,
  mrfr_cfg_if.sink    cfg_ch
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int RAW = AW + 1;

  cfg_t              cfg;
  status_t           status;
  logic              s0_ready;
  logic              fire;
  logic              wr_en;
  logic [RAW-1:0]    wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [RAW-1:0]    rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign in_ch.ready = s0_ready;
  assign fire        = in_ch.valid && s0_ready;

  mrfr_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mrfr_frame_ctrl #(.FRAME_BYTES(FRAME_BYTES)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .action  (in_ch.action),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .status  (status)
  );

  mrfr_frame_ram #(.FRAME_BYTES(FRAME_BYTES)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mrfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .status   (status),
    .rd_data  (rd_data),
    .s0_ready (s0_ready),
    .out_ch   (out_ch)
  );

  // Assembly and delivery never touch the same bank in one cycle
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr[RAW-1] != rd_addr[RAW-1]))
    else $error("frame RAM read and write hit the same bank");

  // A RAM read is issued only for a delivered byte
  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (fire && status.data_valid))
    else $error("frame RAM read without a delivered byte");

  // No pending bytes reported outside assembly
  a_pending_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.receiving) |-> (out_ch.bytes_pending == '0))
    else $error("bytes pending while not receiving");

  // A released frame reports no length
  a_length_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.frame_waiting) |-> (out_ch.frame_length == '0))
    else $error("frame length without a waiting frame");

endmodule

// File: dv/tb_modbus_rtu_frame_receiver.sv
// Self-checking testbench of the Modbus RTU frame receiver, with its frame tracker.
`timescale 1ns / 100ps

module tb_modbus_rtu_frame_receiver import mrfr_pkg::*; ();

  localparam int HOLD_CYCLES = 400;
  localparam int SHOWN_ERRORS = 10;

  // One status transaction of the output channel
  typedef struct packed {
    logic             receiving;
    logic [LEN_W-1:0] bytes_pending;
    logic             frame_waiting;
    logic [LEN_W-1:0] frame_length;
    logic [BYTE_W-1:0] data_byte;
    logic             data_valid;
    logic             data_last;
  } frame_result_t;

  // Tracks assembly, silence and delivery, and holds the status each action should give
  class rtu_frame_tracker;
    localparam int DEPTH = FRAME_BYTES_DEF;

    logic [TIME_W-1:0] gap_limit;
    logic [TIME_W-1:0] end_limit;
    logic [LEN_W-1:0]  capacity;
    logic [LEN_W-1:0]  read_cap;

    bit                assembling;
    int unsigned       asm_count;
    bit                armed;
    int unsigned       silence;
    logic [BYTE_W-1:0] asm_bytes[DEPTH];
    logic [BYTE_W-1:0] out_bytes[DEPTH];
    int unsigned       frame_len;
    bit                frame_held;
    int unsigned       rd_pos;

    frame_result_t     due_status[$];
    int unsigned       errors;

    function new();
      gap_limit = 16'd750;
      end_limit = 16'd1750;
      capacity = 9'd256;
      read_cap = 9'd256;
      silence = 0;
      errors = 0;
      stop_assembly();
      drop_frame();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GAP_LIMIT:  gap_limit = val;
        REG_END_LIMIT:  end_limit = val;
        REG_FRAME_CAP:  capacity = val[LEN_W-1:0];
        REG_READ_LIMIT: read_cap = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Capacity clamped to the buffer: zero acts as one
    function int unsigned usable();
      int unsigned c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    function void stop_assembly();
      assembling = 0;
      asm_count = 0;
      armed = 0;
    endfunction

    function void drop_frame();
      frame_held = 0;
      frame_len = 0;
      rd_pos = 0;
    endfunction

    function void start_frame(logic [BYTE_W-1:0] b);
      asm_bytes[0] = b;
      asm_count = 1;
      assembling = 1;
      silence = 0;
      armed = 1;
    endfunction

    function void on_byte(logic [BYTE_W-1:0] b);
      if (!assembling) begin
        if (!frame_held) start_frame(b);
        return;
      end
      // Gap longer than T1.5: restart, or stop if the delivery side is occupied
      if (silence > gap_limit) begin
        if (frame_held) stop_assembly();
        else start_frame(b);
        return;
      end
      // Overflowing bytes are dropped but still restart the silence count
      if (asm_count < usable()) begin
        asm_bytes[asm_count] = b;
        asm_count++;
      end
      silence = 0;
      armed = 1;
    endfunction

    function void on_tick();
      int unsigned n;
      if (silence < 65535) silence++;
      if (!(armed && assembling && silence >= end_limit)) return;
      n = asm_count;
      stop_assembly();
      if (n == 0 || frame_held) return;
      if (n > usable()) n = usable();
      for (int unsigned i = 0; i < n; i++) out_bytes[i] = asm_bytes[i];
      frame_len = n;
      frame_held = 1;
      rd_pos = 0;
    endfunction

    // Apply one accepted action and queue the status it should produce
    function void note_action(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b);
      frame_result_t r;
      int unsigned lim;
      r = '0;
      case (act)
        ACT_BYTE: on_byte(b);
        ACT_TICK: on_tick();
        ACT_READ: begin
          if (read_cap != 0 && frame_held && frame_len != 0 && rd_pos < frame_len) begin
            lim = (frame_len < read_cap) ? frame_len : read_cap;
            r.data_byte = out_bytes[rd_pos];
            r.data_valid = 1'b1;
            rd_pos++;
            if (rd_pos >= lim) begin
              r.data_last = 1'b1;
              drop_frame();
            end
          end
        end
        ACT_FLUSH, ACT_TX_BEGIN: begin
          stop_assembly();
          drop_frame();
        end
        default: ;
      endcase
      r.receiving = assembling;
      r.bytes_pending = assembling ? LEN_W'(asm_count) : '0;
      r.frame_waiting = frame_held;
      r.frame_length = LEN_W'(frame_len);
      due_status.push_back(r);
    endfunction

    // Compare one output transaction with the oldest awaited status
    function void check_status(frame_result_t got);
      frame_result_t want;
      if (due_status.size() == 0) begin
        if (errors < SHOWN_ERRORS)
          $display("unexpected status transaction at %0t", $time);
        errors++;
        return;
      end
      want = due_status.pop_front();
      if (got.receiving !== want.receiving || got.bytes_pending !== want.bytes_pending ||
          got.frame_waiting !== want.frame_waiting || got.frame_length !== want.frame_length ||
          got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
          got.data_last !== want.data_last) begin
        if (errors < SHOWN_ERRORS) begin
          $display("status mismatch at %0t", $time);
          $display("  expected rcv %b pend %0d wait %b len %0d byte %h valid %b last %b",
                   want.receiving, want.bytes_pending, want.frame_waiting,
                   want.frame_length, want.data_byte, want.data_valid, want.data_last);
          $display("  actual   rcv %b pend %0d wait %b len %0d byte %h valid %b last %b",
                   got.receiving, got.bytes_pending, got.frame_waiting,
                   got.frame_length, got.data_byte, got.data_valid, got.data_last);
        end
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_status.size();
    endfunction

    // Anything still awaited at the end is a failure
    function void close_out();
      if (due_status.size() != 0) begin
        $display("%0d status transactions never arrived", due_status.size());
        errors += due_status.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mrfr_in_if  in_ch ();
  mrfr_out_if out_ch ();
  mrfr_cfg_if cfg_ch ();

  modbus_rtu_frame_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rtu_frame_tracker tracker;

  int unsigned snd_pct = 0;
  int unsigned rcv_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cur_gap, cur_end, cur_cap;
  bit          hold_req = 1'b0;
  logic        hold_active = 1'b0;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #1_000_000;
    $display("tb_modbus_rtu_frame_receiver failed");
    $finish;
  end

  // Receiver: random back-pressure, and no acceptance at all during a long hold-off
  always @(posedge clk) begin
    if (rst || hold_active) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= rcv_pct);
  end

  // Long hold-off of the receiver, counted here while the sender keeps going
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Observe every transaction on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.set_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) tracker.note_action(in_ch.action, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        tracker.check_status('{receiving: out_ch.receiving,
                               bytes_pending: out_ch.bytes_pending,
                               frame_waiting: out_ch.frame_waiting,
                               frame_length: out_ch.frame_length,
                               data_byte: out_ch.data_byte,
                               data_valid: out_ch.data_valid,
                               data_last: out_ch.data_last});
    end
  end

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  // Offer one action, idling first at random, and hold it until taken
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < snd_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic tick_n(input int unsigned n);
    repeat (n) send_item(ACT_TICK, rnd_byte());
  endtask

  task automatic read_bytes(input int unsigned n);
    repeat (n) send_item(ACT_READ, rnd_byte());
  endtask

  // Bytes of one frame with short silences, now and then a gap past T1.5
  task automatic send_frame(input int unsigned len, input bit may_break);
    int unsigned hush;
    for (int unsigned i = 0; i < len; i++) begin
      if (i != 0) begin
        hush = $urandom_range(cur_gap);
        if (may_break && $urandom_range(9) == 0) hush = cur_gap + 1 + $urandom_range(1);
        tick_n(hush);
      end
      send_item(ACT_BYTE, rnd_byte());
    end
  endtask

  // Enough silence to pass T3.5
  task automatic close_frame();
    tick_n(cur_end + $urandom_range(2));
  endtask

  // Write all four registers in one burst of transactions
  task automatic program_regs(input logic [TIME_W-1:0] gap_us, input logic [TIME_W-1:0] end_us,
                              input logic [LEN_W-1:0] cap, input logic [LEN_W-1:0] lim);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] vals[4];
    idx = '{REG_GAP_LIMIT, REG_END_LIMIT, REG_FRAME_CAP, REG_READ_LIMIT};
    vals = '{gap_us, end_us, CFG_DATA_W'(cap), CFG_DATA_W'(lim)};
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_ch.index <= idx[i];
      cfg_ch.data <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_gap = gap_us;
    cur_end = end_us;
    cur_cap = cap;
  endtask

  // Stop offering and wait until every awaited status has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly complete frames with random content and reads, the rest noise
  task automatic run_traffic(input int unsigned count);
    int unsigned stop_at, len, cap_eff;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        cap_eff = (cur_cap < 1) ? 1 : (cur_cap > FRAME_BYTES_DEF) ? FRAME_BYTES_DEF : cur_cap;
        len = $urandom_range(cap_eff + 2, 1);
        send_frame(len, 1'b1);
        close_frame();
        if ($urandom_range(99) < 85) begin
          read_bytes(len + $urandom_range(1));
        end else begin
          read_bytes($urandom_range(len));
          send_item($urandom_range(1) ? ACT_FLUSH : ACT_TX_BEGIN, rnd_byte());
        end
      end else begin
        repeat ($urandom_range(4, 1)) send_item(ACTION_W'($urandom_range(7)), rnd_byte());
      end
    end
  endtask

  initial begin
    tracker = new();
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_TICK;
    in_ch.rx_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_GAP_LIMIT;
    cfg_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sender rarely idles, receiver often stalls
    snd_pct = 6;
    rcv_pct = 54;

    // Directed: empty read, byte extremes, restart on a long gap, frame end,
    // byte while a frame waits, last read, unused actions, flush and transmit
    program_regs(16'd3, 16'd6, 9'd8, 9'd256);
    send_item(ACT_READ, 8'h00);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    tick_n(2);
    send_item(ACT_BYTE, 8'hA5);
    tick_n(4);
    send_item(ACT_BYTE, 8'h5A);
    tick_n(6);
    send_item(ACT_BYTE, 8'h3C);
    send_item(ACT_READ, 8'hFF);
    send_item(ACTION_W'(5), 8'h81);
    send_item(ACTION_W'(6), 8'h42);
    send_item(ACTION_W'(7), 8'h18);
    send_item(ACT_BYTE, 8'h11);
    send_item(ACT_FLUSH, 8'h00);
    send_item(ACT_BYTE, 8'h22);
    send_item(ACT_TX_BEGIN, 8'h00);
    settle();

    program_regs(16'd4, 16'd9, 9'd12, 9'd511);
    run_traffic(180);
    settle();

    // Zero limits and zero capacity
    program_regs(16'd0, 16'd0, 9'd0, 9'd1);
    run_traffic(70);
    settle();

    // Sender often idles, receiver rarely stalls
    snd_pct = 54;
    rcv_pct = 6;
    program_regs(16'd2, 16'd5, 9'd6, 9'd3);
    run_traffic(130);
    settle();

    // Reads disabled
    program_regs(16'd3, 16'd4, 9'd5, 9'd0);
    run_traffic(50);
    settle();

    // No idling; the receiver holds off once so the block fills and stalls
    snd_pct = 0;
    rcv_pct = 0;
    program_regs(16'd6, 16'd12, 9'd20, 9'd256);
    hold_req = 1'b1;
    run_traffic(150);
    settle();

    // Frames past the buffer size, capacity above the buffer, back-to-back bytes
    program_regs(16'd0, 16'd1, 9'd511, 9'd511);
    send_item(ACT_FLUSH, rnd_byte());
    send_frame(260, 1'b0);
    close_frame();
    read_bytes(257);
    settle();

    // Single-byte read limit
    program_regs(16'd0, 16'd1, 9'd256, 9'd1);
    send_frame(8, 1'b0);
    close_frame();
    read_bytes(2);
    settle();

    // Widest limits: a long silence neither breaks nor ends the frame
    program_regs(16'hFFFF, 16'hFFFF, 9'd256, 9'd256);
    send_item(ACT_FLUSH, rnd_byte());
    send_item(ACT_BYTE, 8'hC3);
    send_item(ACT_BYTE, 8'h3C);
    tick_n(20);
    send_item(ACT_BYTE, 8'h99);
    read_bytes(3);
    send_item(ACT_BYTE, 8'h66);
    tick_n(10);
    send_item(ACT_BYTE, 8'h77);
    send_item(ACT_FLUSH, rnd_byte());

    settle();
    repeat (8) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("tb_modbus_rtu_frame_receiver passed");
    end else begin
      $display("tb_modbus_rtu_frame_receiver failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mrfr_pkg.sv
hdl/mrfr_ifs.sv
hdl/mrfr_cfg_regs.sv
hdl/mrfr_frame_ram.sv
hdl/mrfr_frame_ctrl.sv
hdl/mrfr_out_stage.sv
hdl/modbus_rtu_frame_receiver.sv
dv/tb_modbus_rtu_frame_receiver.sv
